[sv/csvp_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_pkg
// shared types and constants of the csv record/field parser
// ---------------------------------------------------------------------------
package csvp_pkg;

    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] DELIM_RESET = 8'd44;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_FIELD  = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_STREAM = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_START_RECORD = 3'd0,
        ST_START_FIELD  = 3'd1,
        ST_IN_FIELD     = 3'd2,
        ST_IN_QUOTED    = 3'd3,
        ST_QUOTE_IN_Q   = 3'd4,
        ST_EAT_LINE_END = 3'd5
    } parse_state_t;

    // results of one input item: cnt of them, in order kind0..kind2
    typedef struct packed {
        logic [1:0] cnt;
        kind_t      kind0;
        kind_t      kind1;
        kind_t      kind2;
        logic [7:0] data;
    } cmd_t;

endpackage
`default_nettype wire

[sv/csvp_if.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_text_if / csvp_token_if
// valid/ready channels for input text bytes and parsed tokens
// ---------------------------------------------------------------------------
interface csvp_text_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] in_byte;

    modport source (output valid, output op, output in_byte, input ready);
    modport sink   (input valid, input op, input in_byte, output ready);
endinterface

interface csvp_token_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface
`default_nettype wire

[sv/csv_record_field_parser_top.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csv_record_field_parser_top
// excel-dialect csv parser: text bytes in, field bytes and field/record/
// stream end tokens out
// ---------------------------------------------------------------------------
// Each accepted text item yields zero to three tokens, delivered one per
// cycle while token.ready is high, the last one flagged by last. The text
// channel takes one item per cycle as long as the QUEUE_DEPTH-entry command
// queue has room; items with no token (an opening quote, a swallowed line
// end) leave nothing in the queue. The token emitter is the rate limit: an
// item that makes two or three tokens (line end after a field, end of input)
// holds the output until its last token is taken; the queue absorbs such
// bursts. Tokens pass the command queue and then the output register. The
// delimiter register resets to a comma; the user must write it through
// cfg_we/cfg_wdata only while the block is idle, not enforced by the block.
// ---------------------------------------------------------------------------
module csv_record_field_parser_top
    import csvp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    csvp_text_if.sink    text,
    csvp_token_if.source token
);

    logic q_push, q_pop, q_empty, q_full;
    cmd_t q_cmd, q_head;

    csvp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .text      (text),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    csvp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    csvp_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .token   (token)
    );

endmodule
`default_nettype wire

[sv/csvp_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_front
// accepts text items, runs the parse state machine and queues the
// result commands of each item
// ---------------------------------------------------------------------------
module csvp_front
    import csvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    csvp_text_if.sink  text,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_cmd
);

    parse_state_t state_reg, state_next, dec_state, bf_state;
    logic [7:0]   delim_reg;
    logic         accept;
    logic         eol, is_delim, is_quote;
    cmd_t         bf_cmd, cmd;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;
    assign eol        = (text.in_byte == CH_LF) || (text.in_byte == CH_CR);
    assign is_delim   = (text.in_byte == delim_reg);
    assign is_quote   = (text.in_byte == CH_QUOTE);

    // first byte of a field, shared by several states
    always_comb
    begin
        bf_cmd       = '{cnt: 2'd0, kind0: KIND_BYTE, kind1: KIND_BYTE, kind2: KIND_BYTE,
                         data: text.in_byte};
        bf_state     = ST_IN_FIELD;
        if (is_delim)
        begin
            bf_cmd.cnt   = 2'd1;
            bf_cmd.kind0 = KIND_FIELD;
            bf_state     = ST_START_FIELD;
        end
        else if (is_quote)
        begin
            bf_state     = ST_IN_QUOTED;
        end
        else
        begin
            bf_cmd.cnt   = 2'd1;
        end
    end

    always_comb
    begin
        cmd       = '{cnt: 2'd0, kind0: KIND_BYTE, kind1: KIND_BYTE, kind2: KIND_BYTE,
                      data: text.in_byte};
        dec_state = state_reg;
        if (text.op == OP_END)
        begin
            dec_state = ST_START_RECORD;
            unique case (state_reg) inside
                ST_START_FIELD, ST_IN_FIELD, ST_IN_QUOTED, ST_QUOTE_IN_Q:
                begin
                    cmd.cnt   = 2'd3;
                    cmd.kind0 = KIND_FIELD;
                    cmd.kind1 = KIND_RECORD;
                    cmd.kind2 = KIND_STREAM;
                end
                default:
                begin
                    cmd.cnt   = 2'd1;
                    cmd.kind0 = KIND_STREAM;
                end
            endcase
        end
        else
        begin
            unique case (state_reg)
                ST_START_FIELD:
                begin
                    if (eol)
                    begin
                        cmd.cnt   = 2'd2;
                        cmd.kind0 = KIND_FIELD;
                        cmd.kind1 = KIND_RECORD;
                        dec_state = ST_START_RECORD;
                    end
                    else
                    begin
                        cmd       = bf_cmd;
                        dec_state = bf_state;
                    end
                end
                ST_IN_FIELD:
                begin
                    if (eol)
                    begin
                        cmd.cnt   = 2'd2;
                        cmd.kind0 = KIND_FIELD;
                        cmd.kind1 = KIND_RECORD;
                        dec_state = ST_START_RECORD;
                    end
                    else if (is_delim)
                    begin
                        cmd.cnt   = 2'd1;
                        cmd.kind0 = KIND_FIELD;
                        dec_state = ST_START_FIELD;
                    end
                    else
                    begin
                        cmd.cnt   = 2'd1;
                    end
                end
                ST_IN_QUOTED:
                begin
                    if (is_quote)
                        dec_state = ST_QUOTE_IN_Q;
                    else
                        cmd.cnt   = 2'd1;
                end
                ST_QUOTE_IN_Q:
                begin
                    // doubled quote, then closing quote followed by delimiter, line end or any other byte
                    if (is_quote)
                    begin
                        cmd.cnt   = 2'd1;
                        dec_state = ST_IN_QUOTED;
                    end
                    else if (is_delim)
                    begin
                        cmd.cnt   = 2'd1;
                        cmd.kind0 = KIND_FIELD;
                        dec_state = ST_START_FIELD;
                    end
                    else if (eol)
                    begin
                        cmd.cnt   = 2'd2;
                        cmd.kind0 = KIND_FIELD;
                        cmd.kind1 = KIND_RECORD;
                        dec_state = ST_EAT_LINE_END;
                    end
                    else
                    begin
                        cmd.cnt   = 2'd1;
                        dec_state = ST_IN_FIELD;
                    end
                end
                ST_EAT_LINE_END:
                begin
                    if (eol)
                        dec_state = ST_EAT_LINE_END;
                    else
                    begin
                        cmd       = bf_cmd;
                        dec_state = bf_state;
                    end
                end
                default:
                begin
                    // start of record; a lone cr emits nothing
                    if (text.in_byte == CH_LF)
                    begin
                        cmd.cnt   = 2'd1;
                        cmd.kind0 = KIND_RECORD;
                        dec_state = ST_START_RECORD;
                    end
                    else if (text.in_byte == CH_CR)
                        dec_state = ST_EAT_LINE_END;
                    else
                    begin
                        cmd       = bf_cmd;
                        dec_state = bf_state;
                    end
                end
            endcase
        end
        state_next = accept ? dec_state : state_reg;
    end

    assign q_push = accept && (cmd.cnt != 2'd0);
    assign q_cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_START_RECORD;
            delim_reg <= DELIM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                delim_reg <= cfg_wdata;
        end
    end

    a_end_resets_state: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (text.op == OP_END)) |=> (state_reg == ST_START_RECORD))
        else $error("end of input did not return to start of record");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

endmodule
`default_nettype wire

[sv/csvp_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_fifo
// short command queue between the parse front end and the token emitter
// ---------------------------------------------------------------------------
module csvp_fifo
    import csvp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic empty,
    output logic full
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == CNT_W'(0));
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");

endmodule
`default_nettype wire

[sv/csvp_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_back
// walks the queued commands and drives one token per cycle, while the
// receiver is ready, through an output register
// ---------------------------------------------------------------------------
module csvp_back
    import csvp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          q_head,
    input  logic          q_empty,
    output logic          q_pop,
    csvp_token_if.source  token
);

    logic       valid_reg, valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] pos_reg, pos_next;
    logic       load, take, at_last;
    kind_t      sel_kind;

    assign load    = !valid_reg || token.ready;
    assign take    = load && !q_empty;
    assign at_last = (pos_reg == (q_head.cnt - 2'd1));
    assign q_pop   = take && at_last;

    always_comb
    begin
        case (pos_reg)
            2'd0:    sel_kind = q_head.kind0;
            2'd1:    sel_kind = q_head.kind1;
            default: sel_kind = q_head.kind2;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        kind_next  = kind_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        pos_next   = pos_reg;
        if (load)
            valid_next = take;
        if (take)
        begin
            kind_next = sel_kind;
            byte_next = (sel_kind == KIND_BYTE) ? q_head.data : 8'd0;
            last_next = at_last;
            pos_next  = at_last ? 2'd0 : pos_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign token.valid    = valid_reg;
    assign token.kind     = kind_reg;
    assign token.out_byte = byte_reg;
    assign token.last     = last_reg;

    // a partly emitted command stays at the queue head
    a_partial_cmd_held: assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg != 2'd0) |-> !q_empty)
        else $error("token position set with empty queue");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (pos_reg < q_head.cnt))
        else $error("token position beyond command length");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (token.valid && token.last))
        else $error("command retired without last token");

endmodule
`default_nettype wire

[tb/csvp_checker.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// csvp_checker
// watches the text and token channels of the csv parser, predicts the tokens
// of every accepted text transaction and compares them in order
// ---------------------------------------------------------------------------
module csvp_checker
    import csvp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    csvp_text_if       text,
    csvp_token_if      token,
    output int         fail_count,
    output int         pending,
    output int         tokens_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } token_exp_t;

    token_exp_t   expected_tokens[$];
    token_exp_t   staged[$];
    parse_state_t pstate;
    logic [7:0]   delim;

    function automatic void emit(kind_t k, logic [7:0] b);
        token_exp_t t;
        t.kind = k;
        t.data = (k == KIND_BYTE) ? b : 8'h00;
        t.last = 1'b0;
        staged = {staged, t};
    endfunction

    // first byte of a field, also the fallthrough out of line-end eating
    function automatic void open_field(logic [7:0] c);
        if (c == delim)
        begin
            emit(KIND_FIELD, 8'h00);
            pstate = ST_START_FIELD;
        end
        else if (c == CH_QUOTE)
        begin
            pstate = ST_IN_QUOTED;
        end
        else
        begin
            emit(KIND_BYTE, c);
            pstate = ST_IN_FIELD;
        end
    endfunction

    function automatic void parse_text(logic op, logic [7:0] c);
        logic eol_seen;
        eol_seen = (c == CH_LF) || (c == CH_CR);
        staged.delete();
        if (op == OP_END)
        begin
            if (pstate inside {ST_START_FIELD, ST_IN_FIELD, ST_IN_QUOTED, ST_QUOTE_IN_Q})
            begin
                emit(KIND_FIELD, 8'h00);
                emit(KIND_RECORD, 8'h00);
            end
            emit(KIND_STREAM, 8'h00);
            pstate = ST_START_RECORD;
        end
        else
        begin
            case (pstate)
                ST_START_FIELD:
                begin
                    if (eol_seen)
                    begin
                        emit(KIND_FIELD, 8'h00);
                        emit(KIND_RECORD, 8'h00);
                        pstate = ST_START_RECORD;
                    end
                    else
                    begin
                        open_field(c);
                    end
                end
                ST_IN_FIELD:
                begin
                    if (eol_seen)
                    begin
                        emit(KIND_FIELD, 8'h00);
                        emit(KIND_RECORD, 8'h00);
                        pstate = ST_START_RECORD;
                    end
                    else if (c == delim)
                    begin
                        emit(KIND_FIELD, 8'h00);
                        pstate = ST_START_FIELD;
                    end
                    else
                    begin
                        emit(KIND_BYTE, c);
                    end
                end
                ST_IN_QUOTED:
                begin
                    if (c == CH_QUOTE)
                        pstate = ST_QUOTE_IN_Q;
                    else
                        emit(KIND_BYTE, c);
                end
                ST_QUOTE_IN_Q:
                begin
                    // quote is tested before the delimiter here
                    if (c == CH_QUOTE)
                    begin
                        emit(KIND_BYTE, CH_QUOTE);
                        pstate = ST_IN_QUOTED;
                    end
                    else if (c == delim)
                    begin
                        emit(KIND_FIELD, 8'h00);
                        pstate = ST_START_FIELD;
                    end
                    else if (eol_seen)
                    begin
                        emit(KIND_FIELD, 8'h00);
                        emit(KIND_RECORD, 8'h00);
                        pstate = ST_EAT_LINE_END;
                    end
                    else
                    begin
                        emit(KIND_BYTE, c);
                        pstate = ST_IN_FIELD;
                    end
                end
                ST_EAT_LINE_END:
                begin
                    if (!eol_seen)
                        open_field(c);
                end
                default:
                begin
                    if (c == CH_LF)
                    begin
                        emit(KIND_RECORD, 8'h00);
                        pstate = ST_START_RECORD;
                    end
                    else if (c == CH_CR)
                    begin
                        pstate = ST_EAT_LINE_END;
                    end
                    else
                    begin
                        open_field(c);
                    end
                end
            endcase
        end
        if (staged.size() > 0)
            staged[staged.size() - 1].last = 1'b1;
        expected_tokens = {expected_tokens, staged};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_exp_t want;
        if (!rst_n)
        begin
            expected_tokens.delete();
            pstate         = ST_START_RECORD;
            delim          = DELIM_RESET;
            fail_count     = 0;
            pending        = 0;
            tokens_checked = 0;
        end
        else
        begin
            if (token.valid && token.ready)
            begin
                tokens_checked++;
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected token, expected none, got kind %0d byte %02h last %b",
                             $time, token.kind, token.out_byte, token.last);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (token.kind !== want.kind)
                    begin
                        fail_count++;
                        $display("%0t: kind expected %0d got %0d", $time, want.kind, token.kind);
                    end
                    if (token.out_byte !== want.data)
                    begin
                        fail_count++;
                        $display("%0t: out_byte expected %02h got %02h",
                                 $time, want.data, token.out_byte);
                    end
                    if (token.last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: last expected %b got %b", $time, want.last, token.last);
                    end
                end
            end
            if (text.valid && text.ready)
                parse_text(text.op, text.in_byte);
            if (cfg_we)
                delim = cfg_wdata;
            pending = expected_tokens.size();
        end
    end

endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// stimulus and verdict for the csv record/field parser: a directed opening
// through every parse state, then random csv records under several delimiter
// settings, with bursty text traffic and a stalling token receiver
// ---------------------------------------------------------------------------
module testbench
    import csvp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_ITEMS    = 18;
    localparam int SETTLE_CYCLES  = 8;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    int fail_count;
    int pending;
    int tokens_checked;
    int items_sent;
    int burst_left;
    int delim_writes;
    int idle_cycles;
    int stall_mode;
    int mode_left;
    int run_left;
    bit run_low;
    logic [7:0] cur_delim;

    csvp_text_if  text_ch();
    csvp_token_if token_ch();

    csv_record_field_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .text      (text_ch),
        .token     (token_ch)
    );

    csvp_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .text           (text_ch),
        .token          (token_ch),
        .fail_count     (fail_count),
        .pending        (pending),
        .tokens_checked (tokens_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // token receiver: free flow, coin flips, or runs of long stalls
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 80);
        end
        mode_left--;
        case (stall_mode)
            0: token_ch.ready <= 1'b1;
            1: token_ch.ready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (run_left == 0)
                begin
                    run_low  = !run_low;
                    run_left = run_low ? $urandom_range(1, 12) : $urandom_range(1, 4);
                end
                run_left--;
                token_ch.ready <= !run_low;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (token_ch.valid && token_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles, %0d tokens still expected",
                     $time, idle_cycles, pending);
            $display("csv_record_field_parser_top: mismatch");
            $finish;
        end
    end

    // one text transaction; bursts of random length with random gaps between
    task automatic send_text(input logic op, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_ch.valid   <= 1'b1;
        text_ch.op      <= op;
        text_ch.in_byte <= b;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic drain();
        text_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic set_delimiter(input logic [7:0] v);
        drain();
        // items that make no token may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cur_delim = v;
        delim_writes++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == cur_delim || b == CH_QUOTE || b == CH_LF || b == CH_CR);
        return b;
    endfunction

    task automatic send_record();
        int nfields;
        int len;
        int style;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++)
        begin
            if (f > 0)
                send_text(OP_DATA, cur_delim);
            style = $urandom_range(0, 9);
            len   = $urandom_range(0, 4);
            if (style < 4)
            begin
                repeat (len) send_text(OP_DATA, plain_byte());
            end
            else if (style < 8)
            begin
                send_text(OP_DATA, CH_QUOTE);
                repeat (len)
                begin
                    case ($urandom_range(0, 5))
                        0: send_text(OP_DATA, cur_delim);
                        1: send_text(OP_DATA, CH_LF);
                        2: send_text(OP_DATA, CH_CR);
                        3:
                        begin
                            send_text(OP_DATA, CH_QUOTE);
                            send_text(OP_DATA, CH_QUOTE);
                        end
                        default: send_text(OP_DATA, plain_byte());
                    endcase
                end
                // broken record: input ends inside the quotes
                if (style == 7 && $urandom_range(0, 1) == 1)
                begin
                    send_text(OP_END, 8'($urandom_range(0, 255)));
                    return;
                end
                send_text(OP_DATA, CH_QUOTE);
                if ($urandom_range(0, 3) == 0)
                    send_text(OP_DATA, plain_byte());
            end
            else
            begin
                repeat (len + 1) send_text(OP_DATA, 8'($urandom_range(0, 255)));
            end
        end
        case ($urandom_range(0, 7))
            0, 1, 2: send_text(OP_DATA, CH_LF);
            3:       send_text(OP_DATA, CH_CR);
            4, 5:
            begin
                send_text(OP_DATA, CH_CR);
                send_text(OP_DATA, CH_LF);
            end
            6:       send_text(OP_END, 8'($urandom_range(0, 255)));
            default:
            begin
                send_text(OP_DATA, CH_LF);
                send_text(OP_DATA, CH_LF);
            end
        endcase
    endtask

    // walks every state with the reset comma: blank line, lone cr, doubled
    // quotes, junk after a closing quote, and end of input from four of the states
    logic [8:0] opening_items[] = '{
        {OP_DATA, CH_LF},    {OP_DATA, CH_CR},    {OP_DATA, CH_LF},    {OP_DATA, DELIM_RESET},
        {OP_DATA, CH_QUOTE}, {OP_DATA, DELIM_RESET}, {OP_DATA, CH_LF}, {OP_DATA, CH_QUOTE},
        {OP_DATA, CH_QUOTE}, {OP_DATA, CH_QUOTE}, {OP_DATA, 8'h7A},   {OP_DATA, 8'hFF},
        {OP_DATA, DELIM_RESET}, {OP_DATA, CH_CR}, {OP_DATA, 8'h00},   {OP_DATA, CH_LF},
        {OP_END, 8'hA5},     {OP_DATA, CH_QUOTE}, {OP_END, 8'h5A},    {OP_DATA, CH_QUOTE},
        {OP_DATA, CH_QUOTE}, {OP_DATA, CH_CR},    {OP_END, 8'hFF},    {OP_DATA, CH_QUOTE},
        {OP_DATA, CH_QUOTE}, {OP_DATA, DELIM_RESET}, {OP_END, 8'h00}
    };

    logic [7:0] delim_plan[8] = '{8'h3B, 8'h00, 8'hFF, CH_QUOTE, CH_LF, 8'h09, 8'h00, DELIM_RESET};

    initial
    begin
        logic [7:0] next_delim;
        int target;
        text_ch.valid   <= 1'b0;
        text_ch.op      <= OP_DATA;
        text_ch.in_byte <= 8'h00;
        cfg_we          <= 1'b0;
        cfg_wdata       <= 8'h00;
        cur_delim       = DELIM_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_items[i])
            send_text(opening_items[i][8], opening_items[i][7:0]);

        target = items_sent;
        for (int p = 0; p < 8; p++)
        begin
            next_delim = (p == 6) ? 8'($urandom_range(0, 255)) : delim_plan[p];
            set_delimiter(next_delim);
            target += PHASE_ITEMS;
            while (items_sent < target)
                send_record();
        end

        drain();
        repeat (SETTLE_CYCLES + 4) @(posedge clk);
        $display("%0d text items sent under %0d delimiter settings, %0d tokens checked",
                 items_sent, delim_writes + 1, tokens_checked);
        if (fail_count == 0)
            $display("csv_record_field_parser_top: match");
        else
            $display("csv_record_field_parser_top: mismatch");
        $finish;
    end

endmodule
`default_nettype wire

[csv_record_field_parser_top.f]
sv/csvp_pkg.sv
sv/csvp_if.sv
sv/csvp_front.sv
sv/csvp_fifo.sv
sv/csvp_back.sv
sv/csv_record_field_parser_top.sv
tb/csvp_checker.sv
tb/testbench.sv
